/* rtl/core/tfs_pkg.sv */
// Shared types, constants and the mixing ROM for the table frame scrambler.
// No dependencies; tfs_front, tfs_queue, tfs_back and the top unit use this package.
package tfs_pkg;

    localparam logic [7:0] KEY_RESET    = 8'h33;
    localparam logic [7:0] KEY_WRAP     = 8'hE0;
    localparam logic [7:0] ADD_OFFSET   = 8'd81;
    localparam logic [7:0] SUB_OFFSET   = 8'd46;
    localparam logic [4:0] ENC_LAST_POS = 5'd29;  // position of the 30th encrypt word
    localparam logic [4:0] DEC_LAST_POS = 5'd31;  // checksum word of a decrypt frame
    localparam logic [4:0] DEC_PAY_POS  = 5'd3;   // first payload word of a decrypt frame
    localparam logic [4:0] CHECK_POS    = 5'd31;  // scramble position of the checksum

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ENC_FIRST,   // key word, then scrambled first header word
        OP_ENC,         // one scrambled word
        OP_ENC_LAST,    // scrambled last word, then scrambled checksum
        OP_DEC_KEY,     // key word of a decrypt frame, no result
        OP_DEC_HDR,     // header word, summed but not emitted
        OP_DEC_PAY,     // payload word
        OP_DEC_LAST     // checksum word, final result
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] pos;
        logic [7:0] key;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    localparam logic [7:0] MIX_ROM [256] = '{
        8'hBC,8'h8B,8'hE5,8'h35,8'h1D,8'h0E,8'hAE,8'h23,8'hB9,8'h4D,8'hFE,8'h50,8'h15,8'hC7,8'h25,8'h60,
        8'hA5,8'hD8,8'h1E,8'h9A,8'h6B,8'h9A,8'hD5,8'hC0,8'h60,8'hCC,8'h50,8'h57,8'hBB,8'h93,8'hB3,8'h49,
        8'h94,8'h25,8'hF6,8'h22,8'h31,8'hFD,8'h9A,8'hF0,8'hDC,8'h04,8'hB6,8'h53,8'hCD,8'h1B,8'hEE,8'h70,
        8'h50,8'h44,8'h20,8'hCE,8'hB3,8'h2B,8'h7A,8'hD7,8'h91,8'hE3,8'h9E,8'hCD,8'hCF,8'h0D,8'hB6,8'hFD,
        8'hF6,8'hB4,8'h29,8'h6B,8'hB3,8'hDE,8'hC7,8'h7F,8'hEF,8'h08,8'hEC,8'h63,8'h88,8'hA8,8'h0A,8'h51,
        8'hF9,8'hCA,8'h6A,8'h42,8'hC6,8'h84,8'h1F,8'hBB,8'hCE,8'h52,8'h3C,8'h0F,8'h11,8'h0C,8'hC9,8'h74,
        8'hE2,8'h99,8'h90,8'h85,8'h8D,8'h6F,8'hCD,8'hD3,8'hCE,8'h65,8'hF9,8'h63,8'h23,8'h96,8'h15,8'h40,
        8'h0C,8'h79,8'h95,8'h87,8'h8E,8'hD3,8'h20,8'h56,8'h10,8'hC3,8'h3A,8'h94,8'hFA,8'h56,8'hC5,8'h65,
        8'h25,8'hBA,8'h61,8'hE9,8'hC5,8'h09,8'h29,8'hB6,8'h34,8'h76,8'hED,8'h80,8'hCF,8'hFF,8'h8A,8'h49,
        8'h9A,8'hF0,8'hCF,8'h7D,8'hC4,8'h6A,8'hB9,8'hF9,8'hE1,8'hA4,8'h97,8'hFB,8'h47,8'h6D,8'h8C,8'h6A,
        8'h2F,8'hB7,8'h00,8'hB2,8'h65,8'hA0,8'hE4,8'h6A,8'h53,8'hD8,8'h7E,8'h1C,8'hFC,8'hE1,8'h92,8'h8F,
        8'hB2,8'hEA,8'hCB,8'hFF,8'h8B,8'h62,8'h99,8'h2E,8'h71,8'h95,8'h96,8'hB9,8'h89,8'h61,8'h32,8'h20,
        8'h1A,8'h4B,8'h5F,8'hDE,8'h23,8'h3A,8'hAE,8'hD7,8'hBE,8'h12,8'h6D,8'h07,8'h28,8'h2B,8'h61,8'hAE,
        8'hC5,8'h04,8'h54,8'h2E,8'h71,8'hA2,8'hD6,8'hD2,8'h42,8'h37,8'h37,8'h8D,8'hBC,8'h0E,8'h27,8'h9A,
        8'h50,8'h8A,8'h6D,8'h42,8'hBA,8'h1B,8'h89,8'hBC,8'h18,8'hD6,8'h1A,8'h09,8'h79,8'h1D,8'h46,8'hBF,
        8'h9A,8'h44,8'h2F,8'h26,8'hCF,8'h1A,8'h92,8'h8F,8'h1D,8'hD4,8'hB6,8'h6F,8'hD9,8'hC8,8'hAA,8'h68
    };

    // ROM entry for key k at frame position r
    function automatic logic [7:0] rom_at(input logic [7:0] k, input logic [4:0] r);
        logic [7:0] base;
        logic [7:0] idx;
        base = (k < KEY_WRAP) ? k : k - KEY_WRAP;
        idx  = base + 8'(r) - 8'd1;
        return MIX_ROM[idx];
    endfunction

    function automatic logic [7:0] scramble(input logic [7:0] k, input logic [4:0] r,
                                            input logic [7:0] b);
        logic [7:0] a;
        logic [7:0] m;
        a = k + ADD_OFFSET + 8'({r, 1'b0}) + (b ^ rom_at(k, r));
        m = k - SUB_OFFSET + 8'(r);
        return a ^ m;
    endfunction

    function automatic logic [7:0] unscramble(input logic [7:0] k, input logic [4:0] r,
                                              input logic [7:0] c);
        logic [7:0] m;
        logic [7:0] v;
        m = k - SUB_OFFSET + 8'(r);
        v = (c ^ m) - 8'({r, 1'b0}) - (k + ADD_OFFSET);
        return v ^ rom_at(k, r);
    endfunction

endpackage

/* rtl/core/tfs_if.sv */
// Valid/ready channel interfaces for the input and result words.
// No dependencies.
interface tfs_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       restart;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output restart, output data_byte, input ready);
    modport sink   (input valid, input mode, input restart, input data_byte, output ready);
endinterface

interface tfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;
    logic       check_error;

    modport source (output valid, output out_byte, output frame_last, output check_error,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_last, input check_error,
                    output ready);
endinterface

/* rtl/core/tfs_front.sv */
// Front end: accepts input words, tracks framing and emits one command per word.
// Depends on tfs_pkg and tfs_in_if.
module tfs_front (
    input  logic              clk,
    input  logic              rst_n,
    tfs_in_if.sink            in_ch,
    input  logic [7:0]        key_byte,
    input  logic              q_full,
    output logic              push_valid,
    output tfs_pkg::cmd_t     push_cmd
);

    logic [4:0] pos_reg, pos_next;
    logic       last_mode_reg;
    logic [7:0] frame_key_reg, frame_key_next;
    logic [4:0] p_eff;
    logic       accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign push_valid  = accept;

    // restart or a mode change realigns to the start of a frame
    assign p_eff = (in_ch.restart || (in_ch.mode != last_mode_reg)) ? 5'd0 : pos_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        frame_key_next = frame_key_reg;
        push_cmd.op    = tfs_pkg::OP_ENC;
        push_cmd.pos   = p_eff;
        push_cmd.key   = frame_key_reg;
        push_cmd.data  = in_ch.data_byte;
        if (!in_ch.mode)
        begin
            push_cmd.pos = p_eff + 5'd1;
            if (p_eff == 5'd0)
            begin
                push_cmd.op    = tfs_pkg::OP_ENC_FIRST;
                push_cmd.key   = key_byte;
                frame_key_next = key_byte;
                pos_next       = 5'd1;
            end
            else if (p_eff >= tfs_pkg::ENC_LAST_POS)
            begin
                push_cmd.op = tfs_pkg::OP_ENC_LAST;
                pos_next    = 5'd0;
            end
            else
            begin
                pos_next = p_eff + 5'd1;
            end
        end
        else
        begin
            if (p_eff == 5'd0)
            begin
                push_cmd.op    = tfs_pkg::OP_DEC_KEY;
                frame_key_next = in_ch.data_byte;
                pos_next       = 5'd1;
            end
            else if (p_eff >= tfs_pkg::DEC_LAST_POS)
            begin
                push_cmd.op = tfs_pkg::OP_DEC_LAST;
                pos_next    = 5'd0;
            end
            else
            begin
                push_cmd.op = (p_eff >= tfs_pkg::DEC_PAY_POS) ? tfs_pkg::OP_DEC_PAY
                                                               : tfs_pkg::OP_DEC_HDR;
                pos_next    = p_eff + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 5'd0;
            last_mode_reg <= 1'b0;
            frame_key_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            last_mode_reg <= in_ch.mode;
            frame_key_reg <= frame_key_next;
        end
    end

endmodule

/* rtl/core/tfs_queue.sv */
// Short command queue between the front end and the back end.
// Depends on tfs_pkg.
module tfs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  tfs_pkg::cmd_t      push_cmd,
    input  logic               pop_ready,
    output tfs_pkg::cmd_t      pop_cmd,
    output tfs_pkg::q_stat_t   stat
);

    tfs_pkg::cmd_t                mem_reg [tfs_pkg::Q_DEPTH];
    logic [tfs_pkg::Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tfs_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic                         push, pop;

    assign stat.full  = (cnt_reg == tfs_pkg::Q_CNT_W'(tfs_pkg::Q_DEPTH));
    assign stat.valid = (cnt_reg != '0);
    assign push       = push_valid && !stat.full;
    assign pop        = pop_ready && stat.valid;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tfs_pkg::Q_PTR_W'(tfs_pkg::Q_DEPTH - 1)) ? '0
                                                                                    : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tfs_pkg::Q_PTR_W'(tfs_pkg::Q_DEPTH - 1)) ? '0
                                                                                    : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/tfs_back.sv */
// Back end: runs queued commands through the ROM mixer, keeps the checksum,
// and drives the registered result channel. Depends on tfs_pkg and tfs_out_if.
module tfs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tfs_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    tfs_out_if.source      out_ch
);

    logic       phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_err_reg;

    logic       advance;
    logic       emit;
    logic [7:0] res_byte;
    logic       res_last;
    logic       res_err;
    logic       check_phase;
    logic [4:0] sc_pos;
    logic [7:0] sc_in;
    logic [7:0] enc_c;
    logic [7:0] dec_v;
    logic [7:0] dec_sum;
    logic [7:0] rel;

    assign advance = cmd_valid && (!out_valid_reg || out_ch.ready);

    // second word of an encrypt last command scrambles the checksum
    assign check_phase = (cmd.op == tfs_pkg::OP_ENC_LAST) && phase_reg;
    assign sc_pos      = check_phase ? tfs_pkg::CHECK_POS : cmd.pos;
    assign sc_in       = check_phase ? sum_reg : cmd.data;
    assign enc_c       = tfs_pkg::scramble(cmd.key, sc_pos, sc_in);
    assign dec_v       = tfs_pkg::unscramble(cmd.key, cmd.pos, cmd.data);
    assign dec_sum     = sum_reg + dec_v;
    assign rel         = dec_sum + cmd.key - {dec_v[6:0], 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        res_byte   = enc_c;
        res_last   = 1'b0;
        res_err    = 1'b0;
        if (advance)
        begin
            unique case (cmd.op)
                tfs_pkg::OP_ENC_FIRST:
                begin
                    emit = 1'b1;
                    if (!phase_reg)
                    begin
                        res_byte   = cmd.key;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        sum_next   = cmd.key + cmd.data;
                        phase_next = 1'b0;
                        cmd_ready  = 1'b1;
                    end
                end
                tfs_pkg::OP_ENC:
                begin
                    emit      = 1'b1;
                    sum_next  = sum_reg + cmd.data;
                    cmd_ready = 1'b1;
                end
                tfs_pkg::OP_ENC_LAST:
                begin
                    emit = 1'b1;
                    if (!phase_reg)
                    begin
                        sum_next   = sum_reg + cmd.data;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        res_last   = 1'b1;
                        phase_next = 1'b0;
                        cmd_ready  = 1'b1;
                    end
                end
                tfs_pkg::OP_DEC_KEY:
                begin
                    sum_next  = 8'd0;
                    cmd_ready = 1'b1;
                end
                tfs_pkg::OP_DEC_HDR:
                begin
                    sum_next  = dec_sum;
                    cmd_ready = 1'b1;
                end
                tfs_pkg::OP_DEC_PAY:
                begin
                    emit      = 1'b1;
                    res_byte  = dec_v;
                    sum_next  = dec_sum;
                    cmd_ready = 1'b1;
                end
                tfs_pkg::OP_DEC_LAST:
                begin
                    emit      = 1'b1;
                    res_byte  = dec_v;
                    res_last  = 1'b1;
                    res_err   = (rel != 8'd0);
                    sum_next  = dec_sum;
                    cmd_ready = 1'b1;
                end
                default:
                begin
                    cmd_ready = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_byte_reg <= res_byte;
            out_last_reg <= res_last;
            out_err_reg  <= res_err;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.frame_last  = out_last_reg;
    assign out_ch.check_error = out_err_reg;

endmodule

/* rtl/core/table_frame_scrambler_unit.sv */
// Table frame scrambler: 32-byte frame scrambling with a fixed 256-byte ROM.
// in_ch  : valid/ready words {mode, restart, data_byte}; mode 0 encrypt, 1 decrypt.
// out_ch : valid/ready result words {out_byte, frame_last, check_error}.
// cfg    : cfg_wr_en/cfg_wr_data load the frame key byte (reset 0x33), write only.
// Encrypt: 30 input words per frame give 32 results (key, 30 scrambled, checksum).
// Decrypt: 32 input words per frame give 28 payload results and one final word
//   with frame_last set and check_error flagging a bad checksum.
// Path: an accepted input word is written into the command queue, then the back
//   end mixes it and loads its result into the output register that drives
//   out_ch.
// Throughput: while out_ch is not stalled the back end retires up to one command per
//   cycle and produces at most one result word per cycle; the first and last encrypt
//   words each give two results from one command. Input words are taken every cycle while the two-entry queue has room.
// Stall: when out_ch.ready is low while a word is held, the output register keeps it,
//   the back end stops, and the queue fills; in_ch.ready drops only once the queue is full.
// Reset: framing, checksum, queue and output valid clear; key byte returns to 0x33.
// Depends on tfs_pkg, tfs_if, tfs_front, tfs_queue and tfs_back.
module table_frame_scrambler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    tfs_in_if.sink      in_ch,
    tfs_out_if.source   out_ch
);

    logic [7:0]         key_byte_reg;
    logic               push_valid;
    tfs_pkg::cmd_t      push_cmd;
    tfs_pkg::cmd_t      head_cmd;
    tfs_pkg::q_stat_t   q_stat;
    logic               cmd_ready;

    // key register; the user must write it only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_byte_reg <= tfs_pkg::KEY_RESET;
        end
        else if (cfg_wr_en)
        begin
            key_byte_reg <= cfg_wr_data;
        end
    end

    // front: framing and classification of each accepted word
    tfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .key_byte   (key_byte_reg),
        .q_full     (q_stat.full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // decouples the front from back-end stalls
    tfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .pop_ready  (cmd_ready),
        .pop_cmd    (head_cmd),
        .stat       (q_stat)
    );

    // back: ROM mixing, checksum and the result register
    tfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (q_stat.valid),
        .cmd_ready (cmd_ready),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    // the checksum flag only ever rides on a frame's final word
    a_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (!out_ch.check_error || out_ch.frame_last))
        else $error("check_error without frame_last");

    // a full queue can never be empty
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.valid)
        else $error("queue full flag with no entries");

    // the back end pops only a present command
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> q_stat.valid)
        else $error("command popped from empty queue");
`endif

endmodule

/* sim/tfs_frame_checker.sv */
// Frame cipher helpers and the result checker for table_frame_scrambler_unit.
// Depends on tfs_pkg (ROM, reset key); the checker watches both channels and cfg.
`timescale 1ns / 1ps

package frame_cipher_pkg;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int ENC_WORDS     = 30;   // input words of an encrypt frame
    localparam int DEC_WORDS     = 32;   // input words of a decrypt frame
    localparam int FIRST_PAYLOAD = 3;    // first decrypt position that gives a result

    localparam logic [7:0] CHECK_ROW = 8'd31;
    localparam logic [7:0] WRAP_KEY  = 8'hE0;
    localparam logic [7:0] KEY_ADD   = 8'd81;
    localparam logic [7:0] KEY_SUB   = 8'd46;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } result_word_t;

    function automatic logic [7:0] table_entry(input logic [7:0] k, input logic [7:0] row);
        logic [7:0] base;
        logic [7:0] idx;
        base = (k < WRAP_KEY) ? k : k - WRAP_KEY;
        idx  = base + row - 8'd1;
        return tfs_pkg::MIX_ROM[idx];
    endfunction

    function automatic logic [7:0] scramble_byte(input logic [7:0] k, input logic [7:0] row,
                                                 input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] mask;
        acc  = k + KEY_ADD + (row << 1) + (b ^ table_entry(k, row));
        mask = k - KEY_SUB + row;
        return acc ^ mask;
    endfunction

    function automatic logic [7:0] unscramble_byte(input logic [7:0] k, input logic [7:0] row,
                                                   input logic [7:0] c);
        logic [7:0] mask;
        logic [7:0] acc;
        mask = k - KEY_SUB + row;
        acc  = (c ^ mask) - (row << 1) - (k + KEY_ADD);
        return acc ^ table_entry(k, row);
    endfunction

endpackage

module tfs_frame_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       in_mode,
    input  logic       in_restart,
    input  logic [7:0] in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    input  logic       out_err,
    output int         errors,
    output int         pending
);

    import frame_cipher_pkg::*;

    logic [7:0]   key_reg;
    logic [4:0]   frame_pos;
    logic [7:0]   frame_sum;
    logic [7:0]   frame_key;
    logic         prev_mode;
    int           fail_cnt;
    result_word_t expected_words[$];

    task automatic expect_word(input logic [7:0] value, input logic last, input logic err);
        result_word_t w;
        w.value = value;
        w.last  = last;
        w.err   = err;
        expected_words.push_back(w);
    endtask

    task automatic predict_word(input logic m, input logic rs, input logic [7:0] d);
        logic [7:0] row;
        logic [7:0] v;
        logic [7:0] rel;
        if (rs || m != prev_mode)
            frame_pos = '0;
        prev_mode = m;
        if (m == MODE_ENC)
        begin
            row = 8'(frame_pos) + 8'd1;
            if (frame_pos == '0)
            begin
                // key latched at frame start and sent in the clear
                frame_key = key_reg;
                frame_sum = key_reg;
                expect_word(key_reg, 1'b0, 1'b0);
            end
            frame_sum = frame_sum + d;
            expect_word(scramble_byte(frame_key, row, d), 1'b0, 1'b0);
            if (int'(row) >= ENC_WORDS)
            begin
                expect_word(scramble_byte(frame_key, CHECK_ROW, frame_sum), 1'b1, 1'b0);
                frame_pos = '0;
            end
            else
                frame_pos = row[4:0];
        end
        else if (frame_pos == '0)
        begin
            frame_key = d;
            frame_sum = '0;
            frame_pos = 5'd1;
        end
        else
        begin
            v = unscramble_byte(frame_key, 8'(frame_pos), d);
            frame_sum = frame_sum + v;
            if (int'(frame_pos) >= DEC_WORDS - 1)
            begin
                rel = frame_sum + frame_key - (v << 1);
                expect_word(v, 1'b1, rel != 8'd0);
                frame_pos = '0;
            end
            else
            begin
                if (int'(frame_pos) >= FIRST_PAYLOAD)
                    expect_word(v, 1'b0, 1'b0);
                frame_pos = frame_pos + 5'd1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   = tfs_pkg::KEY_RESET;
            frame_pos = '0;
            frame_sum = '0;
            frame_key = '0;
            prev_mode = MODE_ENC;
            fail_cnt  = 0;
            expected_words.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // results first: nothing accepted at this edge can already be on out_ch
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: out_byte %02h frame_last %0b check_error %0b",
                           out_byte, out_last, out_err);
                    fail_cnt++;
                end
                else
                begin
                    result_word_t w;
                    w = expected_words.pop_front();
                    if (out_byte !== w.value)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h", w.value, out_byte);
                        fail_cnt++;
                    end
                    if (out_last !== w.last)
                    begin
                        $error("frame_last mismatch: expected %0b, actual %0b", w.last, out_last);
                        fail_cnt++;
                    end
                    if (out_err !== w.err)
                    begin
                        $error("check_error mismatch: expected %0b, actual %0b", w.err, out_err);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_word(in_mode, in_restart, in_data);
            if (cfg_wr_en)
                key_reg = cfg_wr_data;
            errors  <= fail_cnt;
            pending <= expected_words.size();
        end
    end

endmodule

/* sim/tb_table_frame_scrambler_unit.sv */
// Top-level testbench for table_frame_scrambler_unit: clock, reset, stimulus, verdict.
// Depends on tfs_pkg, tfs_if, the block itself and tfs_frame_checker.sv.
`timescale 1ns / 1ps

module tb_table_frame_scrambler_unit;

    import frame_cipher_pkg::*;

    localparam int IDLE_LIMIT    = 1000;  // cycles without any handshake before giving up
    localparam int SETTLE_CYCLES = 6;     // margin for queued key and header words, which give no result
    localparam int PHASE_WORDS   = 250;
    localparam int NUM_PHASES    = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int errors;
    int pending;
    int words_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;   // set for stretches with back-to-back traffic on both sides

    tfs_in_if  in_ch ();
    tfs_out_if out_ch ();

    table_frame_scrambler_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    tfs_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_mode     (in_ch.mode),
        .in_restart  (in_ch.restart),
        .in_data     (in_ch.data_byte),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .out_last    (out_ch.frame_last),
        .out_err     (out_ch.check_error),
        .errors      (errors),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: ready drops for a random stall, then comes back for at least one cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left   <= pick_gap();
            end
        end
    end

    // Watchdog: any accepted word on either channel resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // One input word. Valid stays high after the handshake so back-to-back words
    // only change the payload; a gap lowers it first.
    task automatic send_word(input logic m, input logic rs, input logic [7:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.restart   <= rs;
        in_ch.data_byte <= d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stop sending and wait until every expected result word has come out.
    // The first edge lets the checker count the last accepted word; the settle
    // time covers decrypt key and header words, which give no result.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_key(input logic [7:0] k);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Encrypt frame of random plain bytes; now and then cut short.
    task automatic send_enc_frame();
        logic rs;
        int   len;
        rs  = ($urandom_range(0, 4) != 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, ENC_WORDS - 1) : ENC_WORDS;
        for (int i = 0; i < len; i++)
            send_word(MODE_ENC, (i == 0) ? rs : 1'b0, 8'($urandom));
    endtask

    // Decrypt frame built by scrambling a random plain frame under a random key,
    // so the checksum holds unless one bit is flipped on purpose.
    task automatic send_dec_frame(input bit corrupt);
        logic [7:0] frame [DEC_WORDS];
        logic [7:0] k;
        logic [7:0] csum;
        logic [7:0] plain;
        logic       rs;
        int         bad;
        k        = 8'($urandom);
        csum     = k;
        frame[0] = k;
        for (int r = 1; r < DEC_WORDS - 1; r++)
        begin
            plain    = 8'($urandom);
            csum     = csum + plain;
            frame[r] = scramble_byte(k, 8'(r), plain);
        end
        frame[DEC_WORDS - 1] = scramble_byte(k, CHECK_ROW, csum);
        if (corrupt)
        begin
            bad        = $urandom_range(1, DEC_WORDS - 1);
            frame[bad] = frame[bad] ^ (8'd1 << $urandom_range(0, 7));
        end
        rs = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < DEC_WORDS; i++)
            send_word(MODE_DEC, (i == 0) ? rs : 1'b0, frame[i]);
    endtask

    // Short burst of arbitrary words: random mode, restart and data.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
            send_word(1'($urandom), ($urandom_range(0, 3) == 0), 8'($urandom));
    endtask

    initial
    begin
        logic [7:0] phase_key;
        int         target;
        int         roll;

        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 8'h00;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_ENC;
        in_ch.restart   = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset key, data extremes, restart in each mode, mode changes.
        send_word(MODE_ENC, 1'b0, 8'h00);   // first word under the reset key
        send_word(MODE_ENC, 1'b0, 8'hFF);
        send_word(MODE_ENC, 1'b0, 8'h80);
        send_word(MODE_ENC, 1'b1, 8'h7F);   // restart mid-frame: new key word
        send_word(MODE_ENC, 1'b0, 8'h55);
        send_word(MODE_DEC, 1'b0, 8'hFF);   // mode change drops the partial frame; key wraps
        send_word(MODE_DEC, 1'b0, 8'h00);   // headers: no result
        send_word(MODE_DEC, 1'b0, 8'hFF);
        send_word(MODE_DEC, 1'b0, 8'h00);   // payload
        send_word(MODE_DEC, 1'b0, 8'hFF);
        send_word(MODE_DEC, 1'b1, 8'hE0);   // restart in decrypt: this word is the key
        send_word(MODE_DEC, 1'b0, 8'h12);
        send_word(MODE_DEC, 1'b0, 8'h34);
        send_word(MODE_DEC, 1'b0, 8'hAB);
        send_word(MODE_ENC, 1'b0, 8'hC3);   // back to encrypt without restart
        send_word(MODE_ENC, 1'b1, 8'h3C);
        wait_drained();
        write_key(8'hFF);
        send_word(MODE_ENC, 1'b1, 8'h00);
        send_word(MODE_ENC, 1'b0, 8'hFF);
        wait_drained();
        write_key(8'h00);
        send_word(MODE_ENC, 1'b1, 8'hFF);
        send_word(MODE_DEC, 1'b1, 8'hDF);   // last key below the wrap point
        send_word(MODE_DEC, 1'b0, 8'h00);
        wait_drained();

        // Random phases, each under its own key; extremes and the wrap edge first.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_key = 8'h00;
                1:       phase_key = 8'hFF;
                2:       phase_key = 8'hE0;
                3:       phase_key = 8'hDF;
                4:       phase_key = 8'h33;
                default: phase_key = 8'($urandom);
            endcase
            write_key(phase_key);
            no_idle = (phase == 2 || phase == 5);
            target  = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    send_enc_frame();
                else if (roll < 75)
                    send_dec_frame(1'b0);
                else if (roll < 85)
                    send_dec_frame(1'b1);
                else if (roll < 96)
                    send_noise();
                else
                    wait_drained();   // sender holds off until all results are out
            end
            wait_drained();
        end
        no_idle = 1'b0;

        // wait_drained already waited out the pipeline after the last word
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* table_frame_scrambler_unit.f */
rtl/core/tfs_pkg.sv
rtl/core/tfs_if.sv
rtl/core/tfs_front.sv
rtl/core/tfs_queue.sv
rtl/core/tfs_back.sv
rtl/core/table_frame_scrambler_unit.sv
sim/tfs_frame_checker.sv
sim/tb_table_frame_scrambler_unit.sv
